### rtl/core/nonlinear_ladder_lowpass_core_defines.svh
// Assertion macros shared by the filter core.
`ifndef NONLINEAR_LADDER_LOWPASS_CORE_DEFINES_SVH
`define NONLINEAR_LADDER_LOWPASS_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NLL_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NLL_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/nll_pkg.sv
package nll_pkg;

  // Fixed point format and datapath widths.
  localparam int FracBits = 22;
  localparam int AccWidth = 64;
  localparam int MulBWidth = 25;
  localparam int DigitWidth = 4;
  localparam int DigitSteps = (MulBWidth + DigitWidth - 1) / DigitWidth;
  localparam int CntWidth = $clog2(DigitSteps + 1);
  localparam int StageWidth = 32;
  localparam int RomWidth = 24;
  localparam int InnerWidth = 34;
  localparam int DriveWidth = 40;
  localparam int FracWidth = 25;

  // Configuration port.
  localparam int CfgIdxWidth = 3;
  localparam int CfgDataWidth = 24;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_COEF_H0   = 3'd0,
    REG_COEF_H1   = 3'd1,
    REG_COEF_POLE = 3'd2,
    REG_RESONANCE = 3'd3,
    REG_GAIN_COMP = 3'd4
  } cfg_reg_t;

  localparam logic signed [23:0] CoefPoleReset = 24'sd4194304;
  localparam logic [22:0] GainCompReset = 23'd2097152;

  // Request to the shared multiply-accumulate unit.
  typedef struct packed {
    logic                        start;
    logic                        clear;
    logic signed [AccWidth-1:0]  a;
    logic [MulBWidth-1:0]        b;
    logic signed [AccWidth-1:0]  bias;
  } mac_req_t;

  // Status of the multiply-accumulate unit.
  typedef struct packed {
    logic busy;
    logic done;
  } mac_rsp_t;

endpackage

### rtl/core/nll_ifs.sv
interface nll_in_if #(parameter int SAMPLE_WIDTH = 24) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface nll_out_if #(parameter int SAMPLE_WIDTH = 24) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;
  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

interface nll_cfg_if ();
  import nll_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [CfgIdxWidth-1:0]  index;
  logic [CfgDataWidth-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/core/nonlinear_ladder_lowpass_core.sv
// Four-pole nonlinear ladder low-pass, one sample in and one sample out.
// 14 products run through one shared unit when the drive lies outside the tanh
// span, 15 inside it; the unit takes a 4-bit multiplier digit per cycle.
// A new input beat is accepted only once the previous sample has gone to the
// output register, which waits while the last output has not been taken.
// Reset (synchronous, active high) clears the stage memory and loads register defaults.
module nonlinear_ladder_lowpass_core #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int TANH_TABLE_SIZE = 1024
) (
  input  logic      clk,
  input  logic      rst,
  nll_in_if.sink    in,
  nll_out_if.source out,
  nll_cfg_if.sink   cfg
);
  import nll_pkg::*;

  localparam int AddrWidth = $clog2(TANH_TABLE_SIZE + 1);
  localparam int PosWidth = FracWidth + AddrWidth;
  localparam logic signed [AccWidth-1:0] Bias22 = 64'sd2097152;
  localparam logic signed [AccWidth-1:0] Bias20 = 64'sd524288;
  localparam logic signed [AccWidth-1:0] Bias25 = 64'sd16777216;
  localparam logic signed [DriveWidth-1:0] DriveMax = 40'sd16777216;
  localparam logic signed [StageWidth-1:0] OneQ22 = 32'sd4194304;
  localparam logic signed [AccWidth-1:0] StageMax = 64'sd2147483647;
  localparam logic signed [AccWidth-1:0] StageMin = -64'sd2147483648;
  localparam logic signed [StageWidth:0] OutMax =
    (StageWidth+1)'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [StageWidth:0] OutMin = -OutMax - 33'sd1;

  typedef enum logic [12:0] {
    ST_IDLE  = 13'b0000000000001,
    ST_GAIN  = 13'b0000000000010,
    ST_RES   = 13'b0000000000100,
    ST_DRIVE = 13'b0000000001000,
    ST_ROM0  = 13'b0000000010000,
    ST_ROM1  = 13'b0000000100000,
    ST_LERP0 = 13'b0000001000000,
    ST_LERP  = 13'b0000010000000,
    ST_SA    = 13'b0000100000000,
    ST_SB    = 13'b0001000000000,
    ST_SC    = 13'b0010000000000,
    ST_SD    = 13'b0100000000000,
    ST_FIN   = 13'b1000000000000
  } state_t;

  state_t state;

  logic [22:0]        coef_h0;
  logic [22:0]        coef_h1;
  logic signed [23:0] coef_pole;
  logic [22:0]        resonance;
  logic [22:0]        gain_comp;

  logic signed [SAMPLE_WIDTH-1:0] x_reg;
  logic signed [StageWidth-1:0]   line [5];
  logic signed [StageWidth-1:0]   w_prev;
  logic signed [DriveWidth-1:0]   u_reg;
  logic [AddrWidth-1:0]           rom_addr;
  logic signed [RomWidth-1:0]     rom_data;
  logic signed [RomWidth-1:0]     r0;
  logic [FracWidth-1:0]           frac_reg;
  logic [1:0]                     stage_cnt;
  logic                           out_valid;
  logic signed [SAMPLE_WIDTH-1:0] out_sample;

  mac_req_t                   mac_req;
  mac_rsp_t                   mac_rsp;
  logic signed [AccWidth-1:0] acc;

  logic                           in_fire;
  logic signed [AccWidth-1:0]     acc_s20;
  logic signed [AccWidth-1:0]     acc_s22;
  logic signed [AccWidth-1:0]     acc_s25;
  logic signed [InnerWidth-1:0]   inner;
  logic signed [DriveWidth-1:0]   u_next;
  logic [FracWidth-1:0]           drive_off;
  logic [PosWidth-1:0]            pos;
  logic signed [StageWidth-1:0]   w0;
  logic signed [StageWidth-1:0]   w_sat;
  logic signed [StageWidth:0]     w_wide;
  logic signed [SAMPLE_WIDTH-1:0] out_next;
  logic                           pole_neg;
  logic [23:0]                    pole_mag;
  logic                           out_free;

  nll_mac u_mac (
    .clk (clk),
    .rst (rst),
    .req (mac_req),
    .rsp (mac_rsp),
    .acc (acc)
  );

  nll_tanh_rom #(.TableSize(TANH_TABLE_SIZE)) u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_data)
  );

  assign in_fire = in.valid && in.ready;
  assign in.ready = (state == ST_IDLE);
  assign out.valid = out_valid;
  assign out.sample_out = out_sample;
  assign cfg.ready = 1'b1;
  assign out_free = !out_valid || out.ready;

  // Rounded rescaling of the accumulator (bias was preloaded).
  assign acc_s20 = acc >>> 20;
  assign acc_s22 = acc >>> FracBits;
  assign acc_s25 = acc >>> 25;

  // Feedback mix, tanh table position and interpolation.
  assign inner = InnerWidth'(line[4]) - InnerWidth'(acc_s22);
  assign u_next = DriveWidth'(x_reg) - DriveWidth'(acc_s20);
  assign drive_off = FracWidth'(u_reg + DriveMax);
  assign pos = PosWidth'(drive_off) * PosWidth'(TANH_TABLE_SIZE);
  assign w0 = StageWidth'(r0) + StageWidth'(acc_s25);

  // Stage result saturates to 32 bits; the output to the sample width.
  always_comb begin
    if (acc_s22 > StageMax) w_sat = StageWidth'(StageMax);
    else if (acc_s22 < StageMin) w_sat = StageWidth'(StageMin);
    else w_sat = StageWidth'(acc_s22);
  end

  assign w_wide = (StageWidth+1)'(w_prev);
  always_comb begin
    if (w_wide > OutMax) out_next = SAMPLE_WIDTH'(OutMax);
    else if (w_wide < OutMin) out_next = SAMPLE_WIDTH'(OutMin);
    else out_next = SAMPLE_WIDTH'(w_prev);
  end

  assign pole_neg = coef_pole[23];
  assign pole_mag = pole_neg ? (~coef_pole + 24'd1) : coef_pole;

  // Products issued to the shared multiply-accumulate unit.
  always_comb begin
    mac_req = '0;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          mac_req.start = 1'b1;
          mac_req.clear = 1'b1;
          mac_req.bias = Bias22;
          mac_req.a = AccWidth'(in.sample_in);
          mac_req.b = MulBWidth'(gain_comp);
        end
      end
      ST_GAIN: begin
        if (mac_rsp.done) begin
          mac_req.start = 1'b1;
          mac_req.clear = 1'b1;
          mac_req.bias = Bias20;
          mac_req.a = AccWidth'(inner);
          mac_req.b = MulBWidth'(resonance);
        end
      end
      ST_LERP0: begin
        mac_req.start = 1'b1;
        mac_req.clear = 1'b1;
        mac_req.bias = Bias25;
        mac_req.a = AccWidth'(rom_data) - AccWidth'(r0);
        mac_req.b = frac_reg;
      end
      ST_SA: begin
        mac_req.start = 1'b1;
        mac_req.clear = 1'b1;
        mac_req.bias = Bias22;
        mac_req.a = AccWidth'(w_prev);
        mac_req.b = MulBWidth'(coef_h0);
      end
      ST_SB: begin
        if (mac_rsp.done) begin
          mac_req.start = 1'b1;
          mac_req.a = AccWidth'(line[0]);
          mac_req.b = MulBWidth'(coef_h1);
        end
      end
      ST_SC: begin
        if (mac_rsp.done) begin
          mac_req.start = 1'b1;
          mac_req.a = pole_neg ? -AccWidth'(line[1]) : AccWidth'(line[1]);
          mac_req.b = MulBWidth'(pole_mag);
        end
      end
      default: begin
        mac_req = '0;
      end
    endcase
  end

  // Sequencer, stage memory shift line and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      stage_cnt <= '0;
      coef_h0   <= '0;
      coef_h1   <= '0;
      coef_pole <= CoefPoleReset;
      resonance <= '0;
      gain_comp <= GainCompReset;
      for (int i = 0; i < 5; i++) begin
        line[i] <= '0;
      end
    end else begin
      if (out_valid && out.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg_reg_t'(cfg.index))
          REG_COEF_H0:   coef_h0 <= cfg.data[22:0];
          REG_COEF_H1:   coef_h1 <= cfg.data[22:0];
          REG_COEF_POLE: coef_pole <= cfg.data[23:0];
          REG_RESONANCE: resonance <= cfg.data[22:0];
          REG_GAIN_COMP: gain_comp <= cfg.data[22:0];
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            x_reg <= in.sample_in;
            state <= ST_GAIN;
          end
        end
        ST_GAIN: begin
          if (mac_rsp.done) state <= ST_RES;
        end
        ST_RES: begin
          if (mac_rsp.done) begin
            u_reg <= u_next;
            state <= ST_DRIVE;
          end
        end
        ST_DRIVE: begin
          stage_cnt <= '0;
          if (u_reg < -DriveMax) begin
            w_prev <= -OneQ22;
            state  <= ST_SA;
          end else if (u_reg >= DriveMax) begin
            w_prev <= OneQ22;
            state  <= ST_SA;
          end else begin
            rom_addr <= pos[PosWidth-1 -: AddrWidth];
            frac_reg <= pos[FracWidth-1:0];
            state    <= ST_ROM0;
          end
        end
        ST_ROM0: begin
          rom_addr <= rom_addr + 1'b1;
          state    <= ST_ROM1;
        end
        ST_ROM1: begin
          r0    <= rom_data;
          state <= ST_LERP0;
        end
        ST_LERP0: begin
          state <= ST_LERP;
        end
        ST_LERP: begin
          if (mac_rsp.done) begin
            w_prev <= w0;
            state  <= ST_SA;
          end
        end
        ST_SA: begin
          state <= ST_SB;
        end
        ST_SB: begin
          if (mac_rsp.done) state <= ST_SC;
        end
        ST_SC: begin
          if (mac_rsp.done) state <= ST_SD;
        end
        ST_SD: begin
          if (mac_rsp.done) begin
            for (int i = 0; i < 4; i++) begin
              line[i] <= line[i+1];
            end
            line[4]   <= w_prev;
            w_prev    <= w_sat;
            stage_cnt <= stage_cnt + 1'b1;
            state     <= (stage_cnt == 2'd3) ? ST_FIN : ST_SA;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            for (int i = 0; i < 4; i++) begin
              line[i] <= line[i+1];
            end
            line[4]    <= w_prev;
            out_sample <= out_next;
            out_valid  <= 1'b1;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `include "nonlinear_ladder_lowpass_core_defines.svh"

  `NLL_ASSERT_IMP(a_mac_start_idle, clk, rst, mac_req.start, !mac_rsp.busy, "product while busy")
  `NLL_ASSERT_NXT(a_accept_starts, clk, rst, in_fire, state == ST_GAIN, "beat did not start")
  `NLL_ASSERT_IMP(a_ready_quiet, clk, rst, in.ready, !mac_rsp.busy && !mac_rsp.done, "ready in flight")

endmodule

### rtl/core/nll_mac.sv
module nll_mac (
  input  logic                                 clk,
  input  logic                                 rst,
  input  nll_pkg::mac_req_t                    req,
  output nll_pkg::mac_rsp_t                    rsp,
  output logic signed [nll_pkg::AccWidth-1:0]  acc
);
  import nll_pkg::*;

  logic signed [AccWidth-1:0] mcand;
  logic [MulBWidth-1:0]       mplier;
  logic [CntWidth-1:0]        cnt;
  logic                       busy;
  logic                       done;
  logic signed [AccWidth-1:0] partial;

  // One 4-bit digit of the multiplier per cycle, least significant first.
  assign partial = mcand * $signed({1'b0, mplier[DigitWidth-1:0]});

  assign rsp.busy = busy;
  assign rsp.done = done;

  // Step counter; done pulses once the last digit is in the accumulator.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CntWidth'(DigitSteps);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CntWidth'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Operand shift registers and accumulator.
  always_ff @(posedge clk) begin
    if (req.start) begin
      if (req.clear) begin
        acc <= req.bias;
      end
      mcand  <= req.a;
      mplier <= req.b;
    end else if (busy) begin
      acc    <= acc + partial;
      mcand  <= mcand <<< DigitWidth;
      mplier <= mplier >> DigitWidth;
    end
  end

endmodule

### rtl/core/nll_tanh_rom.sv
module nll_tanh_rom #(
  parameter int TableSize = 1024
) (
  input  logic                                 clk,
  input  logic [$clog2(TableSize+1)-1:0]       addr,
  output logic signed [nll_pkg::RomWidth-1:0]  data
);
  import nll_pkg::*;

  localparam int Depth = TableSize + 1;
  localparam logic [63:0] OneQ30 = 64'd1073741824;
  localparam logic [63:0] Ln2Q30 = 64'd744261118;

  typedef logic signed [RomWidth-1:0] rom_table_t [Depth];

  // Series term divided by its index, for indexes 1 to 13.
  function automatic logic [63:0] div_small(logic [63:0] t, int i);
    case (i)
      1:       return t;
      2:       return t / 2;
      3:       return t / 3;
      4:       return t / 4;
      5:       return t / 5;
      6:       return t / 6;
      7:       return t / 7;
      8:       return t / 8;
      9:       return t / 9;
      10:      return t / 10;
      11:      return t / 11;
      12:      return t / 12;
      13:      return t / 13;
      default: return t;
    endcase
  endfunction

  // tanh at x = -4 + 8k/TableSize in Q.22, via exp(-2|x|) in Q.30.
  function automatic logic signed [RomWidth-1:0] entry(int k);
    logic signed [63:0] d;
    logic [63:0] ad, y, n, f, term, sum, e, num, den, rem, quo;
    int i;
    d = 64'(8 * k) - 64'(4 * TableSize);
    ad = (d < 0) ? -d : d;
    y = ((ad << 1) << 30) / TableSize;
    n = y / Ln2Q30;
    f = y - n * Ln2Q30;
    term = OneQ30;
    sum = OneQ30;
    for (i = 1; i <= 13; i++) begin
      term = div_small((term * f) >> 30, i);
      if ((i & 1) != 0) sum = sum - term;
      else sum = sum + term;
    end
    if (n >= 62) e = '0;
    else if (n > 0) e = (sum + (64'd1 << (n - 1))) >> n;
    else e = sum;
    num = ((OneQ30 - e) << 22) + ((OneQ30 + e) >> 1);
    den = OneQ30 + e;
    rem = '0;
    quo = '0;
    // Restoring division, one quotient bit per step.
    for (i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      quo = quo << 1;
      if (rem >= den) begin
        rem = rem - den;
        quo[0] = 1'b1;
      end
    end
    if (d < 0) return RomWidth'(-quo);
    return RomWidth'(quo);
  endfunction

  function automatic rom_table_t build_table();
    rom_table_t t;
    for (int k = 0; k < Depth; k++) begin
      t[k] = entry(k);
    end
    return t;
  endfunction

  localparam rom_table_t TanhTable = build_table();

  // Registered read port.
  always_ff @(posedge clk) begin
    data <= TanhTable[addr];
  end

endmodule
